// ----- src/utf8sd_pkg.sv -----
// Shared types, constants and helpers for the strict UTF-8 decoder.
// No dependencies; every other file of the block uses this package.
package utf8sd_pkg;

  localparam int OFFSET_BITS_DEF = 32;
  localparam int OUT_OFF_W       = 32;
  localparam int CP_W            = 21;
  localparam int LEN_W           = 3;
  localparam int FIFO_DEPTH      = 4;
  localparam int FIFO_PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Byte class bounds
  localparam logic [7:0] ASCII_MAX  = 8'h7F;
  localparam logic [7:0] LEAD2_MIN  = 8'hC2;
  localparam logic [7:0] LEAD2_MAX  = 8'hDF;
  localparam logic [7:0] LEAD3_MIN  = 8'hE0;
  localparam logic [7:0] LEAD3_MAX  = 8'hEF;
  localparam logic [7:0] LEAD4_MIN  = 8'hF0;
  localparam logic [7:0] LEAD4_MAX  = 8'hF4;
  localparam logic [7:0] LEAD_ED    = 8'hED;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;
  localparam logic [7:0] E0_CONT_MIN = 8'hA0;
  localparam logic [7:0] ED_CONT_MAX = 8'h9F;
  localparam logic [7:0] F0_CONT_MIN = 8'h90;
  localparam logic [7:0] F4_CONT_MAX = 8'h8F;

  typedef enum logic [1:0] {
    KIND_SCALAR = 2'd0,
    KIND_OK     = 2'd1,
    KIND_ERR    = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                  kind;
    logic [CP_W-1:0]        code_point;
    logic [OUT_OFF_W-1:0]   start_ofs;
    logic [LEN_W-1:0]       n_bytes;
    logic                   last_of_run;
  } res_t;

  // Results of one decode step, in order; count is 0..2
  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
  } res_pair_t;

  function automatic res_t make_res(kind_t k, logic [CP_W-1:0] cp,
                                    logic [OUT_OFF_W-1:0] off,
                                    logic [LEN_W-1:0] len);
    res_t r;
    r.kind        = k;
    r.code_point  = cp;
    r.start_ofs   = off;
    r.n_bytes     = len;
    r.last_of_run = 1'b0;
    return r;
  endfunction

endpackage

// ----- src/utf8sd_step.sv -----
// Decode state and the single-step decode logic for one stream item.
// Depends on utf8sd_pkg.
module utf8sd_step #(
  parameter int OFFSET_BITS = utf8sd_pkg::OFFSET_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  logic [7:0]            data_byte,
  input  logic                  byte_present,
  input  logic                  end_of_input,
  output utf8sd_pkg::res_pair_t results
);

  logic [utf8sd_pkg::CP_W-1:0]  pv_r,   pv_nxt;
  logic [1:0]                   need_r, need_nxt;
  logic [utf8sd_pkg::LEN_W-1:0] slen_r, slen_nxt;
  logic [7:0]                   lead_r, lead_nxt;
  logic                         fcp_r,  fcp_nxt;
  logic [OFFSET_BITS-1:0]       sso_r,  sso_nxt;
  logic [OFFSET_BITS-1:0]       pos_r,  pos_nxt;
  logic                         fail_r, fail_nxt;

  always_comb begin
    utf8sd_pkg::res_t r0, r1;
    logic [1:0]             n;
    logic                   bad;
    logic [OFFSET_BITS-1:0] here;

    r0 = utf8sd_pkg::make_res(utf8sd_pkg::KIND_OK, '0, '0, '0);
    r1 = r0;
    n  = 2'd0;
    bad = 1'b0;
    here = pos_r;
    pv_nxt = pv_r; need_nxt = need_r; slen_nxt = slen_r; lead_nxt = lead_r;
    fcp_nxt = fcp_r; sso_nxt = sso_r; pos_nxt = pos_r; fail_nxt = fail_r;

    if (byte_present) begin
      // saturate the position counter
      if (pos_r != {OFFSET_BITS{1'b1}}) begin
        pos_nxt = pos_r + 1'b1;
      end
      if (!fail_r) begin
        if (need_r == 2'd0) begin
          if (data_byte <= utf8sd_pkg::ASCII_MAX) begin
            r0 = utf8sd_pkg::make_res(utf8sd_pkg::KIND_SCALAR,
                   {{(utf8sd_pkg::CP_W-8){1'b0}}, data_byte},
                   utf8sd_pkg::OUT_OFF_W'(here), utf8sd_pkg::LEN_W'(1));
            n = 2'd1;
          end else if (data_byte inside
                       {[utf8sd_pkg::LEAD2_MIN:utf8sd_pkg::LEAD2_MAX]} ||
                       data_byte inside
                       {[utf8sd_pkg::LEAD3_MIN:utf8sd_pkg::LEAD3_MAX]} ||
                       data_byte inside
                       {[utf8sd_pkg::LEAD4_MIN:utf8sd_pkg::LEAD4_MAX]}) begin
            if (data_byte <= utf8sd_pkg::LEAD2_MAX) begin
              pv_nxt   = utf8sd_pkg::CP_W'(data_byte[4:0]);
              need_nxt = 2'd1;
            end else if (data_byte <= utf8sd_pkg::LEAD3_MAX) begin
              pv_nxt   = utf8sd_pkg::CP_W'(data_byte[3:0]);
              need_nxt = 2'd2;
            end else begin
              pv_nxt   = utf8sd_pkg::CP_W'(data_byte[2:0]);
              need_nxt = 2'd3;
            end
            slen_nxt = utf8sd_pkg::LEN_W'(need_nxt) + 1'b1;
            lead_nxt = data_byte;
            fcp_nxt  = 1'b1;
            sso_nxt  = here;
          end else begin
            fail_nxt = 1'b1;
            sso_nxt  = here;
            r0 = utf8sd_pkg::make_res(utf8sd_pkg::KIND_ERR, '0,
                   utf8sd_pkg::OUT_OFF_W'(here), '0);
            n = 2'd1;
          end
        end else begin
          bad = (data_byte & utf8sd_pkg::CONT_MASK) != utf8sd_pkg::CONT_TAG;
          if (fcp_r) begin
            if (lead_r == utf8sd_pkg::LEAD3_MIN &&
                data_byte < utf8sd_pkg::E0_CONT_MIN) bad = 1'b1;
            if (lead_r == utf8sd_pkg::LEAD_ED &&
                data_byte > utf8sd_pkg::ED_CONT_MAX) bad = 1'b1;
            if (lead_r == utf8sd_pkg::LEAD4_MIN &&
                data_byte < utf8sd_pkg::F0_CONT_MIN) bad = 1'b1;
            if (lead_r == utf8sd_pkg::LEAD4_MAX &&
                data_byte > utf8sd_pkg::F4_CONT_MAX) bad = 1'b1;
          end
          if (bad) begin
            fail_nxt = 1'b1;
            need_nxt = 2'd0;
            r0 = utf8sd_pkg::make_res(utf8sd_pkg::KIND_ERR, '0,
                   utf8sd_pkg::OUT_OFF_W'(sso_r), '0);
            n = 2'd1;
          end else begin
            pv_nxt   = {pv_r[utf8sd_pkg::CP_W-7:0], data_byte[5:0]};
            fcp_nxt  = 1'b0;
            need_nxt = need_r - 1'b1;
            if (need_nxt == 2'd0) begin
              r0 = utf8sd_pkg::make_res(utf8sd_pkg::KIND_SCALAR, pv_nxt,
                     utf8sd_pkg::OUT_OFF_W'(sso_r), slen_r);
              n = 2'd1;
            end
          end
        end
      end
    end

    if (end_of_input) begin
      // a sequence still open at the end is an error of its own
      if (!fail_nxt && need_nxt != 2'd0) begin
        fail_nxt = 1'b1;
        r0 = utf8sd_pkg::make_res(utf8sd_pkg::KIND_ERR, '0,
               utf8sd_pkg::OUT_OFF_W'(sso_nxt), '0);
        n = 2'd1;
      end
      if (n == 2'd0) begin
        r0 = fail_nxt ?
             utf8sd_pkg::make_res(utf8sd_pkg::KIND_ERR, '0,
               utf8sd_pkg::OUT_OFF_W'(sso_nxt), '0) :
             utf8sd_pkg::make_res(utf8sd_pkg::KIND_OK, '0,
               utf8sd_pkg::OUT_OFF_W'(pos_nxt), '0);
      end else begin
        r1 = fail_nxt ?
             utf8sd_pkg::make_res(utf8sd_pkg::KIND_ERR, '0,
               utf8sd_pkg::OUT_OFF_W'(sso_nxt), '0) :
             utf8sd_pkg::make_res(utf8sd_pkg::KIND_OK, '0,
               utf8sd_pkg::OUT_OFF_W'(pos_nxt), '0);
      end
      n = n + 1'b1;
      pv_nxt = '0; need_nxt = '0; slen_nxt = '0; lead_nxt = '0;
      fcp_nxt = 1'b0; sso_nxt = '0; pos_nxt = '0; fail_nxt = 1'b0;
    end

    if (n == 2'd1) r0.last_of_run = 1'b1;
    if (n == 2'd2) r1.last_of_run = 1'b1;

    results.count = n;
    results.r0    = r0;
    results.r1    = r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0; need_r <= '0; slen_r <= '0; lead_r <= '0;
      fcp_r <= 1'b0; sso_r <= '0; pos_r <= '0; fail_r <= 1'b0;
    end else if (fire) begin
      pv_r <= pv_nxt; need_r <= need_nxt; slen_r <= slen_nxt;
      lead_r <= lead_nxt; fcp_r <= fcp_nxt; sso_r <= sso_nxt;
      pos_r <= pos_nxt; fail_r <= fail_nxt;
    end
  end

endmodule

// ----- src/utf8sd_res_fifo.sv -----
// Result queue: takes up to two results a cycle, hands out one.
// Depends on utf8sd_pkg.
module utf8sd_res_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  utf8sd_pkg::res_pair_t push_data,
  input  logic                  pop,
  output utf8sd_pkg::res_t      head,
  output logic                  head_valid,
  output logic                  room,
  output logic [utf8sd_pkg::FIFO_CNT_W-1:0] level
);

  utf8sd_pkg::res_t                   entry_r [utf8sd_pkg::FIFO_DEPTH];
  logic [utf8sd_pkg::FIFO_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [utf8sd_pkg::FIFO_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [utf8sd_pkg::FIFO_CNT_W-1:0]  cnt_r,    cnt_nxt;
  logic [1:0]                         n_push;
  logic                               do_pop;

  assign n_push     = push ? push_data.count : 2'd0;
  assign head_valid = cnt_r != '0;
  assign do_pop     = pop && head_valid;
  assign head       = entry_r[rd_ptr_r];
  // room for a full pair, judged before this cycle's pop
  assign room       = cnt_r <= utf8sd_pkg::FIFO_CNT_W'(utf8sd_pkg::FIFO_DEPTH - 2);
  assign level      = cnt_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + utf8sd_pkg::FIFO_PTR_W'(n_push);
    rd_ptr_nxt = rd_ptr_r + utf8sd_pkg::FIFO_PTR_W'(do_pop);
    cnt_nxt    = cnt_r + utf8sd_pkg::FIFO_CNT_W'(n_push)
                       - utf8sd_pkg::FIFO_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      entry_r[wr_ptr_r] <= push_data.r0;
    end
    if (n_push == 2'd2) begin
      entry_r[wr_ptr_r + 1'b1] <= push_data.r1;
    end
  end

endmodule

// ----- src/utf8_strict_decoder.sv -----
// Strict UTF-8 decoder top level: input register, decode step, result queue.
// Depends on utf8sd_pkg, utf8sd_step and utf8sd_res_fifo.
//
// Usage:
//   Input stream: one request per byte. in_tdata carries the byte, in_tuser
//   says whether the byte is present (clear for an end-only request) and
//   in_tlast ends the stream after that byte.
//   Result stream: out_tuser is the kind (scalar, finished ok, error),
//   out_tdata packs code point, start offset and length, out_tlast marks the
//   last result that one input request causes.
//   Path: a request is held in the input register, decoded, and its results
//   are registered in the result queue, from which out_tvalid is driven.
//   Throughput: one input request per cycle while the result queue has room
//   for a pair; an end-of-stream request that gives two results hands them
//   out one after the other.
//   Stall: a four-entry result queue sits between decode and the output;
//   decode holds while fewer than two entries are free, and in_tready drops
//   once the held input register cannot move on.
//   Reset: rst_n low clears the decode state, the position counter and the
//   queue; the first byte afterwards has offset zero.
module utf8_strict_decoder #(
  parameter int OFFSET_BITS = utf8sd_pkg::OFFSET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] byte_present
  input  logic        in_tlast,   // end_of_input
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [20:0] code_point, [52:21] start_ofs,
                                  // [55:53] n_bytes
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast   // last_of_run
);

  logic                  in_valid_r;
  logic [7:0]            in_byte_r;
  logic                  in_present_r;
  logic                  in_end_r;
  logic                  fire;
  logic                  room;
  utf8sd_pkg::res_pair_t step_res;
  utf8sd_pkg::res_t      head;
  logic [utf8sd_pkg::FIFO_CNT_W-1:0] level;

  // advance the held request into decode when the queue has room for a pair
  assign fire      = in_valid_r && room;
  assign in_tready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r    <= in_tdata;
      in_present_r <= in_tuser;
      in_end_r     <= in_tlast;
    end
  end

  utf8sd_step #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_step (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .data_byte    (in_byte_r),
    .byte_present (in_present_r),
    .end_of_input (in_end_r),
    .results      (step_res)
  );

  utf8sd_res_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (fire),
    .push_data  (step_res),
    .pop        (out_tready),
    .head       (head),
    .head_valid (out_tvalid),
    .room       (room),
    .level      (level)
  );

  assign out_tdata = {head.n_bytes, head.start_ofs, head.code_point};
  assign out_tuser = head.kind;
  assign out_tlast = head.last_of_run;

`ifndef SYNTHESIS
  // the queue never overfills
  assert property (@(posedge clk) disable iff (!rst_n)
    level <= utf8sd_pkg::FIFO_CNT_W'(utf8sd_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  // status results carry no code point and no length
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != utf8sd_pkg::KIND_SCALAR |->
      out_tdata[55:53] == '0 && out_tdata[20:0] == '0)
    else $error("status result with payload");

  // a decoded scalar always has a length of one to four
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == utf8sd_pkg::KIND_SCALAR |->
      out_tdata[55:53] != '0 && out_tdata[55:53] <= 3'd4)
    else $error("scalar with bad length");

  // a held request that cannot decode blocks the input
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !room |-> !in_tready)
    else $error("input taken while decode stalled");
`endif

endmodule
